/* rtl/core/sps_pkg.sv */
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants
// Step codes, the field kind table, the control and status structs and the error codes.
// ----------------------------------------------------------------------------
package sps_pkg;

    localparam int MAX_DIM_DEF    = 16384;
    localparam int MAX_CYCLE_DEF  = 255;
    localparam int SKIP_BYTES_DEF = 4;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_SHORT  = 3'd1;
    localparam logic [2:0] ERR_NOTSPS = 3'd2;
    localparam logic [2:0] ERR_CHROMA = 3'd3;
    localparam logic [2:0] ERR_GOLOMB = 3'd4;
    localparam logic [2:0] ERR_CYCLE  = 3'd5;
    localparam logic [2:0] ERR_SIZE   = 3'd6;

    typedef enum logic [4:0] {
        ST_HDR, ST_CL, ST_SPSID, ST_CHROMA, ST_SEP, ST_DEPTH_L, ST_DEPTH_C,
        ST_BYPASS, ST_MATRIX, ST_LIST_FLAG, ST_DELTA, ST_LOG2FN, ST_POC_TYPE,
        ST_POC_LSB, ST_DZERO, ST_OFF_NONREF, ST_OFF_TB, ST_CYCLE, ST_OFF_REF,
        ST_MAX_REF, ST_GAPS, ST_WIDTH, ST_HEIGHT, ST_FRAME_ONLY, ST_MBAFF,
        ST_DONE
    } step_t;

    // fixed-width field length, zero for Exp-Golomb fields
    function automatic logic [4:0] fixed_len(input step_t s);
        case (s)
            ST_HDR, ST_CL:                                      fixed_len = 5'd16;
            ST_SEP, ST_BYPASS, ST_MATRIX, ST_LIST_FLAG, ST_DZERO,
            ST_GAPS, ST_FRAME_ONLY, ST_MBAFF:                   fixed_len = 5'd1;
            default:                                            fixed_len = 5'd0;
        endcase
    endfunction

    function automatic logic is_high(input logic [7:0] p);
        case (p)
            8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
            8'd118, 8'd128, 8'd138, 8'd139, 8'd134, 8'd135: is_high = 1'b1;
            default:                                        is_high = 1'b0;
        endcase
    endfunction

    // controller to datapath
    typedef struct packed {
        logic       clear;   // start a new unit
        logic       bit_en;  // shift one bit in
        logic       bit_val;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       done;    // parse complete or failed
    } dp_stat_t;

endpackage

/* rtl/core/sps_stream_if.sv */
// ----------------------------------------------------------------------------
// sps_stream_if: valid/ready channel
// Carries a payload of parametrised width between a source and a sink.
// ----------------------------------------------------------------------------
interface sps_stream_if #(
    parameter int W = 9
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/sps_datapath.sv */
// ----------------------------------------------------------------------------
// sps_datapath: bit-serial SPS field sequencer
// Walks the syntax one bit per command and holds the frame size.
// ----------------------------------------------------------------------------
module sps_datapath #(
    parameter int MAX_DIM   = sps_pkg::MAX_DIM_DEF,
    parameter int MAX_CYCLE = sps_pkg::MAX_CYCLE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sps_pkg::dp_cmd_t  cmd,
    output sps_pkg::dp_stat_t stat,
    output logic              ok,
    output logic [2:0]        error_code,
    output logic [14:0]       width,
    output logic [14:0]       height
);
    localparam int UW = $clog2(MAX_DIM / 16 + 1);
    localparam logic [31:0] DIM_UNITS = 32'(MAX_DIM / 16);

    sps_pkg::step_t step_reg, step_next;
    logic [31:0] val_reg, val_next;
    logic [5:0]  pz_reg, pz_next;
    logic [5:0]  btr_reg, btr_next;
    logic        suf_reg, suf_next;
    logic [7:0]  prof_reg, prof_next;
    logic        c444_reg, c444_next;
    logic [7:0]  lc_reg, lc_next;
    logic [6:0]  ec_reg, ec_next;
    logic [7:0]  ls_reg, ls_next;
    logic [UW-1:0] wu_reg, wu_next, hu_reg, hu_next;
    logic        fo_reg, fo_next;
    logic [2:0]  fail_reg, fail_next;

    logic        fin;
    logic [31:0] fv, shv;
    logic [31:0] mag;
    logic [7:0]  ns;
    logic [6:0]  ec_inc;
    logic [7:0]  lc_inc;
    logic        go;
    sps_pkg::step_t tgt;

    // prime a step's field: its fixed bit count, zero for Exp-Golomb fields
    function automatic logic [5:0] init_btr(input sps_pkg::step_t s);
        init_btr = {1'b0, sps_pkg::fixed_len(s)};
    endfunction

    always_comb
    begin
        step_next = step_reg; val_next = val_reg; pz_next = pz_reg;
        btr_next = btr_reg; suf_next = suf_reg; prof_next = prof_reg;
        c444_next = c444_reg; lc_next = lc_reg; ec_next = ec_reg;
        ls_next = ls_reg; wu_next = wu_reg; hu_next = hu_reg;
        fo_next = fo_reg; fail_next = fail_reg;
        fin = 1'b0; fv = 32'd0; go = 1'b0; tgt = sps_pkg::ST_DONE;
        shv = {val_reg[30:0], cmd.bit_val};
        mag = 32'd0; ns = 8'd0; ec_inc = ec_reg + 7'd1; lc_inc = lc_reg + 8'd1;

        if (cmd.bit_en && fail_reg == sps_pkg::ERR_NONE && step_reg != sps_pkg::ST_DONE)
        begin
            if (sps_pkg::fixed_len(step_reg) != 5'd0)
            begin
                val_next = shv;
                if (btr_reg > 6'd0) btr_next = btr_reg - 6'd1;
                if (btr_reg <= 6'd1) begin fin = 1'b1; fv = shv; end
            end
            else if (!suf_reg)
            begin
                if (!cmd.bit_val)
                begin
                    pz_next = pz_reg + 6'd1;
                    if (pz_reg >= 6'd31) fail_next = sps_pkg::ERR_GOLOMB;
                end
                else if (pz_reg == 6'd0) fin = 1'b1;
                else
                begin
                    suf_next = 1'b1; btr_next = pz_reg; val_next = 32'd0;
                end
            end
            else
            begin
                val_next = shv;
                if (btr_reg > 6'd0) btr_next = btr_reg - 6'd1;
                if (btr_reg <= 6'd1)
                begin
                    fin = 1'b1;
                    fv = ((32'd1 << pz_reg[4:0]) - 32'd1) + shv;
                end
            end
        end

        // field complete: act on its value
        if (fin)
        begin
            go = 1'b1;
            case (step_reg)
                sps_pkg::ST_HDR:
                begin
                    prof_next = fv[7:0];
                    if (fv[12:8] != 5'd7) begin fail_next = sps_pkg::ERR_NOTSPS; go = 1'b0; end
                    else tgt = sps_pkg::ST_CL;
                end
                sps_pkg::ST_CL:      tgt = sps_pkg::ST_SPSID;
                sps_pkg::ST_SPSID:
                    tgt = sps_pkg::is_high(prof_reg) ? sps_pkg::ST_CHROMA : sps_pkg::ST_LOG2FN;
                sps_pkg::ST_CHROMA:
                begin
                    if (fv > 32'd3) begin fail_next = sps_pkg::ERR_CHROMA; go = 1'b0; end
                    else
                    begin
                        c444_next = (fv == 32'd3);
                        tgt = (fv == 32'd3) ? sps_pkg::ST_SEP : sps_pkg::ST_DEPTH_L;
                    end
                end
                sps_pkg::ST_SEP:     tgt = sps_pkg::ST_DEPTH_L;
                sps_pkg::ST_DEPTH_L: tgt = sps_pkg::ST_DEPTH_C;
                sps_pkg::ST_DEPTH_C: tgt = sps_pkg::ST_BYPASS;
                sps_pkg::ST_BYPASS:  tgt = sps_pkg::ST_MATRIX;
                sps_pkg::ST_MATRIX:
                begin
                    lc_next = 8'd0;
                    tgt = fv[0] ? sps_pkg::ST_LIST_FLAG : sps_pkg::ST_LOG2FN;
                end
                sps_pkg::ST_LIST_FLAG:
                begin
                    if (fv[0])
                    begin
                        ec_next = 7'd0; ls_next = 8'd8; tgt = sps_pkg::ST_DELTA;
                    end
                    else
                    begin
                        lc_next = lc_inc;
                        tgt = (lc_inc >= (c444_reg ? 8'd12 : 8'd8)) ?
                              sps_pkg::ST_LOG2FN : sps_pkg::ST_LIST_FLAG;
                    end
                end
                sps_pkg::ST_DELTA:
                begin
                    mag = (fv >> 1) + {31'd0, fv[0]};
                    ns = fv[0] ? ls_reg + mag[7:0] : ls_reg - mag[7:0];
                    if (ns != 8'd0) ls_next = ns;
                    ec_next = ec_inc;
                    if (ns == 8'd0 || ec_inc >= (lc_reg < 8'd6 ? 7'd16 : 7'd64))
                    begin
                        lc_next = lc_inc;
                        tgt = (lc_inc >= (c444_reg ? 8'd12 : 8'd8)) ?
                              sps_pkg::ST_LOG2FN : sps_pkg::ST_LIST_FLAG;
                    end
                    else tgt = sps_pkg::ST_DELTA;
                end
                sps_pkg::ST_LOG2FN:  tgt = sps_pkg::ST_POC_TYPE;
                sps_pkg::ST_POC_TYPE:
                    tgt = (fv == 32'd0) ? sps_pkg::ST_POC_LSB :
                          (fv == 32'd1) ? sps_pkg::ST_DZERO : sps_pkg::ST_MAX_REF;
                sps_pkg::ST_POC_LSB:    tgt = sps_pkg::ST_MAX_REF;
                sps_pkg::ST_DZERO:      tgt = sps_pkg::ST_OFF_NONREF;
                sps_pkg::ST_OFF_NONREF: tgt = sps_pkg::ST_OFF_TB;
                sps_pkg::ST_OFF_TB:     tgt = sps_pkg::ST_CYCLE;
                sps_pkg::ST_CYCLE:
                begin
                    if (fv > 32'(MAX_CYCLE)) begin fail_next = sps_pkg::ERR_CYCLE; go = 1'b0; end
                    else
                    begin
                        lc_next = fv[7:0];
                        tgt = (fv[7:0] == 8'd0) ? sps_pkg::ST_MAX_REF : sps_pkg::ST_OFF_REF;
                    end
                end
                sps_pkg::ST_OFF_REF:
                begin
                    lc_next = lc_reg - 8'd1;
                    tgt = (lc_reg == 8'd1) ? sps_pkg::ST_MAX_REF : sps_pkg::ST_OFF_REF;
                end
                sps_pkg::ST_MAX_REF: tgt = sps_pkg::ST_GAPS;
                sps_pkg::ST_GAPS:    tgt = sps_pkg::ST_WIDTH;
                sps_pkg::ST_WIDTH:
                begin
                    wu_next = (fv >= DIM_UNITS) ? DIM_UNITS[UW-1:0] : fv[UW-1:0];
                    tgt = sps_pkg::ST_HEIGHT;
                end
                sps_pkg::ST_HEIGHT:
                begin
                    hu_next = (fv >= DIM_UNITS) ? DIM_UNITS[UW-1:0] : fv[UW-1:0];
                    tgt = sps_pkg::ST_FRAME_ONLY;
                end
                sps_pkg::ST_FRAME_ONLY:
                begin
                    fo_next = fv[0];
                    tgt = fv[0] ? sps_pkg::ST_DONE : sps_pkg::ST_MBAFF;
                end
                default: tgt = sps_pkg::ST_DONE;
            endcase
        end
        if (go)
        begin
            step_next = tgt; val_next = 32'd0; pz_next = 6'd0; suf_next = 1'b0;
            btr_next = init_btr(tgt);
        end

        if (cmd.clear)
        begin
            step_next = sps_pkg::ST_HDR; val_next = 32'd0; pz_next = 6'd0;
            btr_next = init_btr(sps_pkg::ST_HDR); suf_next = 1'b0; prof_next = 8'd0;
            c444_next = 1'b0; lc_next = 8'd0; ec_next = 7'd0; ls_next = 8'd8;
            wu_next = '0; hu_next = '0; fo_next = 1'b0; fail_next = sps_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= sps_pkg::ST_HDR; val_reg <= 32'd0; pz_reg <= 6'd0;
            btr_reg <= init_btr(sps_pkg::ST_HDR); suf_reg <= 1'b0; prof_reg <= 8'd0;
            c444_reg <= 1'b0; lc_reg <= 8'd0; ec_reg <= 7'd0; ls_reg <= 8'd8;
            wu_reg <= '0; hu_reg <= '0; fo_reg <= 1'b0; fail_reg <= sps_pkg::ERR_NONE;
        end
        else
        begin
            step_reg <= step_next; val_reg <= val_next; pz_reg <= pz_next;
            btr_reg <= btr_next; suf_reg <= suf_next; prof_reg <= prof_next;
            c444_reg <= c444_next; lc_reg <= lc_next; ec_reg <= ec_next;
            ls_reg <= ls_next; wu_reg <= wu_next; hu_reg <= hu_next;
            fo_reg <= fo_next; fail_reg <= fail_next;
        end
    end

    // result from the held state
    logic [18:0] w_px, h_px;
    logic [2:0]  code;
    always_comb
    begin
        w_px = (19'(wu_reg) + 19'd1) << 4;
        h_px = ((19'(hu_reg) + 19'd1) << 4) << (fo_reg ? 0 : 1);
        code = fail_reg;
        if (code == sps_pkg::ERR_NONE && step_reg != sps_pkg::ST_DONE)
            code = sps_pkg::ERR_SHORT;
        if (code == sps_pkg::ERR_NONE)
            if (32'(wu_reg) >= DIM_UNITS || 32'(hu_reg) >= DIM_UNITS ||
                32'(w_px) > 32'(MAX_DIM) || 32'(h_px) > 32'(MAX_DIM))
                code = sps_pkg::ERR_SIZE;
    end

    assign stat.done  = (fail_reg != sps_pkg::ERR_NONE) || (step_reg == sps_pkg::ST_DONE);
    assign ok         = (code == sps_pkg::ERR_NONE);
    assign error_code = code;
    assign width      = ok ? w_px[14:0] : 15'd0;
    assign height     = ok ? h_px[14:0] : 15'd0;
endmodule

/* rtl/core/sps_ctrl.sv */
// ----------------------------------------------------------------------------
// sps_ctrl: byte controller
// Skips the prefix, drops emulation bytes, feeds bits and sequences results.
// ----------------------------------------------------------------------------
module sps_ctrl #(
    parameter int SKIP_BYTES = sps_pkg::SKIP_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              in_ready,
    output logic              res_load,
    input  logic              res_free,
    input  sps_pkg::dp_stat_t stat,
    output sps_pkg::dp_cmd_t  cmd
);
    typedef enum logic [1:0] { S_IDLE, S_SHIFT, S_EMIT } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  pc_reg, pc_next;
    logic [1:0]  zr_reg, zr_next;
    logic [7:0]  sh_reg, sh_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic        take, drop;

    assign in_ready = (state_reg == S_IDLE);
    assign take     = in_valid && in_ready;
    assign drop     = (zr_reg == 2'd2) && (in_byte == 8'h03);

    always_comb
    begin
        state_next = state_reg; pc_next = pc_reg; zr_next = zr_reg;
        sh_next = sh_reg; cnt_next = cnt_reg; last_next = last_reg;
        cmd = '0; res_load = 1'b0;
        case (state_reg)
            S_IDLE:
                if (take)
                begin
                    last_next = in_last;
                    if (32'(pc_reg) < SKIP_BYTES)
                    begin
                        pc_next = pc_reg + 3'd1;
                        if (in_last) state_next = S_EMIT;
                    end
                    else
                    begin
                        zr_next = (in_byte == 8'd0) ? ((zr_reg == 2'd2) ? 2'd2 : zr_reg + 2'd1)
                                                    : 2'd0;
                        if (!drop)
                        begin
                            sh_next = in_byte; cnt_next = 3'd0; state_next = S_SHIFT;
                        end
                        else if (in_last) state_next = S_EMIT;
                    end
                end
            S_SHIFT:
            begin
                // one bit a cycle, skipped once parsing has stopped
                cmd.bit_en  = !stat.done;
                cmd.bit_val = sh_reg[7];
                sh_next = {sh_reg[6:0], 1'b0};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7 || stat.done)
                    state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
                if (res_free)
                begin
                    res_load = 1'b1; cmd.clear = 1'b1;
                    pc_next = 3'd0; zr_next = 2'd0; state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; pc_reg <= 3'd0; zr_reg <= 2'd0;
            sh_reg <= 8'd0; cnt_reg <= 3'd0; last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; pc_reg <= pc_next; zr_reg <= zr_next;
            sh_reg <= sh_next; cnt_reg <= cnt_next; last_reg <= last_next;
        end
    end
endmodule

/* rtl/core/h264_sps_frame_size_parser_top.sv */
// ----------------------------------------------------------------------------
// h264_sps_frame_size_parser_top: SPS frame-size parser
// Byte stream in, one frame-size result per unit out.
// ----------------------------------------------------------------------------
// Each input beat carries one raw byte of a NAL unit; the beat with last set
// closes the unit and yields one result beat (ok, error code, width, height).
// A payload byte is accepted and then shifted bit by bit into the bit-serial
// field sequencer, and no new byte is taken until that ends; prefix and dropped
// emulation bytes are only accepted. Once parsing has finished or failed, later
// bytes skip their remaining bits. The result sits in an output register, so the
// next unit may start while it waits to be taken.
module h264_sps_frame_size_parser_top #(
    parameter int MAX_DIM    = sps_pkg::MAX_DIM_DEF,
    parameter int MAX_CYCLE  = sps_pkg::MAX_CYCLE_DEF,
    parameter int SKIP_BYTES = sps_pkg::SKIP_BYTES_DEF
) (
    input logic   clk,
    input logic   rst_n,
    sps_stream_if.sink   in_ch,
    sps_stream_if.source out_ch
);
    sps_pkg::dp_cmd_t  cmd;
    sps_pkg::dp_stat_t stat;
    logic        res_load, ok;
    logic [2:0]  ec;
    logic [14:0] w, h;
    logic        ov_reg;
    logic [33:0] od_reg;

    sps_ctrl #(.SKIP_BYTES(SKIP_BYTES)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_byte(in_ch.data[8:1]), .in_last(in_ch.data[0]),
        .in_ready(in_ch.ready), .res_load(res_load),
        .res_free(!ov_reg || out_ch.ready), .stat(stat), .cmd(cmd)
    );

    sps_datapath #(.MAX_DIM(MAX_DIM), .MAX_CYCLE(MAX_CYCLE)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .ok(ok), .error_code(ec), .width(w), .height(h)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (res_load)
            ov_reg <= 1'b1;
        else if (out_ch.ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            od_reg <= {ok, ec, w, h};
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;

    // a result never overwrites one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!ov_reg || out_ch.ready))
        else $error("result overwritten");
    // no byte taken while a clear is issued
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !in_ch.ready)
        else $error("byte accepted during clear");
    // ok result carries a non-zero width
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.data[33]) |-> (out_ch.data[29:15] != 15'd0))
        else $error("ok with zero width");
endmodule
